FILE: design/clnws_pkg.sv
// Shared types, opcodes and command constants for the character LCD
// nibble write sequencer. No dependencies.
package clnws_pkg;

  localparam int HOLD_W  = 16;
  localparam int WAIT_W  = 24;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    OP_CMD    = 3'd0,
    OP_DATA   = 3'd1,
    OP_SETPOS = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_INIT   = 3'd4
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_HOLD   = 2'd0,
    REG_STARTUP_WAIT = 2'd1,
    REG_BACKLIGHT    = 2'd2
  } cfg_reg_t;

  localparam logic [HOLD_W-1:0] RST_PULSE_HOLD   = 16'd50;
  localparam logic [WAIT_W-1:0] RST_STARTUP_WAIT = 24'd100000;

  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CMD_HOME    = 8'h02;
  localparam logic [7:0] CMD_FUNCSET = 8'h28;
  localparam logic [7:0] CMD_DISPON  = 8'h0C;
  localparam logic [7:0] CMD_ENTRY   = 8'h06;
  localparam logic [3:0] INIT_NIB    = 4'h2;

  // Phase of the enable strobe within one nibble.
  localparam logic [1:0] PH_LOW0 = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW1 = 2'd2;

  // Control from the sequencer to the shared countdown unit.
  typedef struct packed {
    logic              load;
    logic [WAIT_W-1:0] value;
  } tmr_ctl_t;

  function automatic logic [3:0] pick_nib(input logic [7:0] b, input logic lo);
    pick_nib = lo ? b[3:0] : b[7:4];
  endfunction

  // Index of the final nibble of a request.
  function automatic logic [2:0] last_nib(input logic [2:0] op);
    logic [2:0] r;
    r = 3'd1;
    if (op == OP_CLEAR) r = 3'd3;
    else if (op == OP_INIT) r = 3'd6;
    last_nib = r;
  endfunction

  // Nibble number idx of a request; b is the latched byte for byte opcodes.
  function automatic logic [3:0] nib_value(input logic [2:0] op, input logic [7:0] b,
                                           input logic [2:0] idx);
    logic [3:0] r;
    r = 4'h0;
    unique case (op)
      OP_CMD, OP_DATA, OP_SETPOS: r = pick_nib(b, idx[0]);
      OP_CLEAR: r = pick_nib(idx[1] ? CMD_HOME : CMD_CLEAR, idx[0]);
      OP_INIT: begin
        unique case (idx)
          3'd0:       r = INIT_NIB;
          3'd1, 3'd2: r = pick_nib(CMD_FUNCSET, ~idx[0]);
          3'd3, 3'd4: r = pick_nib(CMD_DISPON, ~idx[0]);
          3'd5, 3'd6: r = pick_nib(CMD_ENTRY, ~idx[0]);
          default:    r = 4'h0;
        endcase
      end
      default: r = 4'h0;
    endcase
    nib_value = r;
  endfunction

endpackage

FILE: design/clnws_timer.sv
// Shared countdown unit used for both the startup wait and the per-state
// hold time. Depends on clnws_pkg.
module clnws_timer import clnws_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  tmr_ctl_t ctl,
  output logic     done
);

  logic [WAIT_W-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (ctl.load) count_nxt = ctl.value;
    else if (count_r != '0) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else        count_r <= count_nxt;
  end

  assign done = (count_r == '0);

endmodule

FILE: design/clnws_seq.sv
// Request sequencer: walks nibbles and enable phases, drives the result
// channel and the shared countdown unit. Depends on clnws_pkg.
module clnws_seq import clnws_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_opcode,
  input  logic [7:0]        in_byte_value,
  input  logic              in_row_sel,
  input  logic [5:0]        in_col_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_data_nibble,
  output logic              out_reg_select,
  output logic              out_enable_pin,
  output logic              out_last_state,
  input  logic [HOLD_W-1:0] hold_cycles,
  input  logic [WAIT_W-1:0] startup_cycles,
  output tmr_ctl_t          tmr_ctl,
  input  logic              tmr_done
);

  typedef enum logic [1:0] {S_IDLE, S_START, S_EMIT, S_HOLD} state_t;

  state_t     state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [2:0] nib_r, nib_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       last;
  logic [HOLD_W-1:0] hold_eff;

  // A hold setting of zero is raised to one.
  assign hold_eff = (hold_cycles == '0) ? HOLD_W'(1) : hold_cycles;
  assign last     = (phase_r == PH_LOW1) && (nib_r == last_nib(op_r));

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    byte_nxt      = byte_r;
    nib_nxt       = nib_r;
    phase_nxt     = phase_r;
    tmr_ctl.load  = 1'b0;
    tmr_ctl.value = startup_cycles;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && (in_opcode <= OP_INIT)) begin
          op_nxt    = in_opcode;
          // Set position: 0x80 | row base | column; bottom row base is 0x40.
          byte_nxt  = (in_opcode == OP_SETPOS) ? {1'b1, in_row_sel, in_col_index}
                                               : in_byte_value;
          nib_nxt   = 3'd0;
          phase_nxt = PH_LOW0;
          if (in_opcode == OP_INIT) begin
            tmr_ctl.load = 1'b1;
            state_nxt    = S_START;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_START: begin
        if (tmr_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_stall) begin
          tmr_ctl.load  = 1'b1;
          tmr_ctl.value = WAIT_W'(hold_eff);
          state_nxt     = S_HOLD;
        end
      end
      S_HOLD: begin
        if (tmr_done) begin
          if (last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_EMIT;
            if (phase_r == PH_LOW1) begin
              phase_nxt = PH_LOW0;
              nib_nxt   = nib_r + 3'd1;
            end else begin
              phase_nxt = phase_r + 2'd1;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nib_r   <= '0;
      phase_r <= PH_LOW0;
      op_r    <= OP_CMD;
    end else begin
      state_r <= state_nxt;
      nib_r   <= nib_nxt;
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
    end
    byte_r <= byte_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_EMIT);
  assign out_data_nibble = nib_value(op_r, byte_r, nib_r);
  assign out_reg_select  = (op_r == OP_DATA);
  assign out_enable_pin  = (phase_r == PH_HIGH);
  assign out_last_state  = last;

endmodule

FILE: design/char_lcd_nibble_write_sequencer_top.sv
// Top level of the character LCD 4-bit write sequencer: configuration
// registers, sequencer and shared countdown unit. Depends on clnws_pkg.

// Each accepted request expands into a series of LCD pin states, one output
// transfer per state: a byte is two nibbles, high first, and each nibble is
// three states (EN low, EN high, EN low). Command byte, data byte and set
// position give 6 states, clear gives 12 and init gives 21; opcodes 5 to 7
// are accepted and produce nothing. After each output transfer the state is
// held for the configured pulse hold by the shared countdown unit; init
// first waits the configured startup wait on the same counter. One request
// is in flight at a time: in_stall is high until the last state's hold has
// expired. Output stalls only lengthen the run.
// The bottom row address of set position is 0x40 (not decimal 40).
// Configuration writes are meant for idle periods only.
module char_lcd_nibble_write_sequencer_top import clnws_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_opcode,
  input  logic [7:0]           in_byte_value,
  input  logic                 in_row_sel,
  input  logic [5:0]           in_col_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           out_data_nibble,
  output logic                 out_reg_select,
  output logic                 out_enable_pin,
  output logic                 out_backlight_pin,
  output logic                 out_last_state,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WAIT_W-1:0]    cfg_data
);

  logic [HOLD_W-1:0] hold_r;
  logic [WAIT_W-1:0] startup_r;
  logic              backlight_r;
  tmr_ctl_t          tmr_ctl;
  logic              tmr_done;

  // Config register file; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r      <= RST_PULSE_HOLD;
      startup_r   <= RST_STARTUP_WAIT;
      backlight_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PULSE_HOLD:   hold_r      <= cfg_data[HOLD_W-1:0];
        REG_STARTUP_WAIT: startup_r   <= cfg_data;
        REG_BACKLIGHT:    backlight_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_backlight_pin = backlight_r;

  clnws_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_byte_value   (in_byte_value),
    .in_row_sel      (in_row_sel),
    .in_col_index    (in_col_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_nibble (out_data_nibble),
    .out_reg_select  (out_reg_select),
    .out_enable_pin  (out_enable_pin),
    .out_last_state  (out_last_state),
    .hold_cycles     (hold_r),
    .startup_cycles  (startup_r),
    .tmr_ctl         (tmr_ctl),
    .tmr_done        (tmr_done)
  );

  clnws_timer u_timer (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (tmr_ctl),
    .done  (tmr_done)
  );

endmodule

FILE: design/clnws_checker.sv
// Port-level checks for the LCD write sequencer, bound to the top level.
// Depends on clnws_pkg and char_lcd_nibble_write_sequencer_top.
module clnws_checker import clnws_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [2:0] in_opcode,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_data_nibble,
  input logic       out_last_state
);

  // A valid request keeps the block busy from the next cycle.
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_opcode <= OP_INIT)) |=> in_stall)
    else $error("request transfer did not make the block busy");

  // Results only while a request is in flight.
  a_out_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result offered while input side is idle");

  // Final state is followed by its hold, not another result.
  a_hold_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_state) |=> !out_valid)
    else $error("result offered right after the final state");

  // Stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data_nibble)))
    else $error("stalled result changed");

endmodule

bind char_lcd_nibble_write_sequencer_top clnws_checker u_clnws_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_opcode       (in_opcode),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_data_nibble (out_data_nibble),
  .out_last_state  (out_last_state)
);
